>>> hdl/mactbl_pkg.sv
`default_nettype none

package mactbl_pkg;

    localparam int TABLE_DEPTH_DEFAULT = 32;
    localparam int ADDR_W              = 48;
    localparam int STRENGTH_W          = 8;
    localparam int TIME_W              = 32;
    localparam int SLOT_W              = 5;
    localparam int COUNT_W             = 6;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;

    typedef enum logic [1:0] {
        OUTCOME_HIT     = 2'd0,
        OUTCOME_FILL    = 2'd1,
        OUTCOME_REPLACE = 2'd2
    } outcome_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0]            device_address;
        logic signed [STRENGTH_W-1:0] signal_strength;
        logic [TIME_W-1:0]            time_ms;
    } item_t;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        outcome_t           outcome;
        logic [COUNT_W-1:0] device_count;
    } result_t;

    typedef struct packed {
        logic [ADDR_W-1:0]     address;
        logic [TIME_W-1:0]     last_seen;
        logic [STRENGTH_W-1:0] strength;
    } entry_t;

    // a slot is free when address bytes 0, 1 and 5 are all zero
    function automatic logic addr_is_empty(input logic [ADDR_W-1:0] addr);
        logic [7:0] merged;
        merged = addr[7:0] | addr[15:8] | addr[47:40];
        return (merged == 8'd0);
    endfunction

endpackage

`default_nettype wire

>>> hdl/mactbl_mem.sv
`default_nettype none

module mactbl_mem #(
    parameter int TABLE_DEPTH = mactbl_pkg::TABLE_DEPTH_DEFAULT,
    parameter int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               rd_en,
    input  wire logic [IDX_W-1:0]   rd_addr,
    output mactbl_pkg::entry_t      rd_data,
    input  wire logic               wr_en,
    input  wire logic [IDX_W-1:0]   wr_addr,
    input  wire mactbl_pkg::entry_t wr_data
);

    mactbl_pkg::entry_t     entry_mem [TABLE_DEPTH];
    mactbl_pkg::entry_t     rd_data_reg;
    logic [TABLE_DEPTH-1:0] written_reg;
    logic                   rd_live_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    // entries never written since reset read back as all zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            rd_live_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_live_reg <= written_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_live_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

>>> hdl/mactbl_ctrl.sv
`default_nettype none

module mactbl_ctrl #(
    parameter int TABLE_DEPTH = mactbl_pkg::TABLE_DEPTH_DEFAULT,
    parameter int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire mactbl_pkg::item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output mactbl_pkg::result_t     out_data,
    output logic                    rd_en,
    output logic [IDX_W-1:0]        rd_addr,
    input  wire mactbl_pkg::entry_t rd_data,
    output logic                    wr_en,
    output logic [IDX_W-1:0]        wr_addr,
    output mactbl_pkg::entry_t      wr_data
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    mactbl_pkg::state_t state_reg, state_next;

    logic                          issue_reg, issue_next;
    logic [IDX_W-1:0]              rd_idx_reg, rd_idx_next;
    logic                          cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]              cmp_idx_reg, cmp_idx_next;
    logic                          hit_found_reg, hit_found_next;
    logic [IDX_W-1:0]              hit_idx_reg, hit_idx_next;
    logic                          empty_found_reg, empty_found_next;
    logic [IDX_W-1:0]              empty_idx_reg, empty_idx_next;
    logic [IDX_W-1:0]              min_idx_reg, min_idx_next;
    logic [mactbl_pkg::TIME_W-1:0] min_time_reg, min_time_next;
    logic [mactbl_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                          out_valid_reg, out_valid_next;
    mactbl_pkg::result_t           out_data_reg, out_data_next;
    mactbl_pkg::item_t             item_reg, item_next;

    logic                          accept;
    logic                          scan_last;
    logic                          out_free;
    logic                          commit;
    logic [IDX_W-1:0]              chosen;
    mactbl_pkg::outcome_t          outcome;

    assign accept    = in_valid && in_ready;
    assign scan_last = cmp_valid_reg && (cmp_idx_reg == LAST_IDX);
    assign out_free  = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mactbl_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = mactbl_pkg::ST_SCAN;
                end
            end
            mactbl_pkg::ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = mactbl_pkg::ST_WRITE;
                end
            end
            mactbl_pkg::ST_WRITE:
            begin
                if (out_free)
                begin
                    state_next = mactbl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mactbl_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready = 1'b0;
        rd_en    = 1'b0;
        commit   = 1'b0;
        unique case (state_reg)
            mactbl_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            mactbl_pkg::ST_SCAN:
            begin
                rd_en = issue_reg;
            end
            mactbl_pkg::ST_WRITE:
            begin
                commit = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // hit wins over a free slot, a free slot over the oldest entry
    always_comb
    begin
        if (hit_found_reg)
        begin
            chosen  = hit_idx_reg;
            outcome = mactbl_pkg::OUTCOME_HIT;
        end
        else if (empty_found_reg)
        begin
            chosen  = empty_idx_reg;
            outcome = mactbl_pkg::OUTCOME_FILL;
        end
        else
        begin
            chosen  = min_idx_reg;
            outcome = mactbl_pkg::OUTCOME_REPLACE;
        end
    end

    assign rd_addr = rd_idx_reg;
    assign wr_en   = commit;
    assign wr_addr = chosen;
    assign wr_data = '{address:   item_reg.device_address,
                       last_seen: item_reg.time_ms,
                       strength:  item_reg.signal_strength};

    always_comb
    begin
        item_next        = item_reg;
        issue_next       = issue_reg;
        rd_idx_next      = rd_idx_reg;
        cmp_valid_next   = 1'b0;
        cmp_idx_next     = cmp_idx_reg;
        hit_found_next   = hit_found_reg;
        hit_idx_next     = hit_idx_reg;
        empty_found_next = empty_found_reg;
        empty_idx_next   = empty_idx_reg;
        min_idx_next     = min_idx_reg;
        min_time_next    = min_time_reg;
        count_next       = count_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            item_next        = in_data;
            issue_next       = 1'b1;
            rd_idx_next      = '0;
            hit_found_next   = 1'b0;
            empty_found_next = 1'b0;
        end

        if (rd_en)
        begin
            cmp_valid_next = 1'b1;
            cmp_idx_next   = rd_idx_reg;
            if (rd_idx_reg == LAST_IDX)
            begin
                issue_next = 1'b0;
            end
            else
            begin
                rd_idx_next = rd_idx_reg + 1'b1;
            end
        end

        // one entry per cycle arrives from the memory
        if (cmp_valid_reg)
        begin
            if (!hit_found_reg && (rd_data.address == item_reg.device_address))
            begin
                hit_found_next = 1'b1;
                hit_idx_next   = cmp_idx_reg;
            end
            if (!empty_found_reg && mactbl_pkg::addr_is_empty(rd_data.address))
            begin
                empty_found_next = 1'b1;
                empty_idx_next   = cmp_idx_reg;
            end
            if ((cmp_idx_reg == '0) || (rd_data.last_seen < min_time_reg))
            begin
                min_idx_next  = cmp_idx_reg;
                min_time_next = rd_data.last_seen;
            end
        end

        if (commit)
        begin
            if (outcome == mactbl_pkg::OUTCOME_FILL && count_reg != mactbl_pkg::COUNT_MAX)
            begin
                count_next = count_reg + 1'b1;
            end
            out_valid_next             = 1'b1;
            out_data_next.slot         = mactbl_pkg::SLOT_W'(chosen);
            out_data_next.outcome      = outcome;
            out_data_next.device_count = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= mactbl_pkg::ST_IDLE;
            issue_reg       <= 1'b0;
            cmp_valid_reg   <= 1'b0;
            hit_found_reg   <= 1'b0;
            empty_found_reg <= 1'b0;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            issue_reg       <= issue_next;
            cmp_valid_reg   <= cmp_valid_next;
            hit_found_reg   <= hit_found_next;
            empty_found_reg <= empty_found_next;
            count_reg       <= count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        rd_idx_reg    <= rd_idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        hit_idx_reg   <= hit_idx_next;
        empty_idx_reg <= empty_idx_next;
        min_idx_reg   <= min_idx_next;
        min_time_reg  <= min_time_next;
        out_data_reg  <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

>>> hdl/mac_table_lru_allocate_top.sv
// Device sighting table: each input beat (address, strength, time) is looked up in a
// TABLE_DEPTH-entry fully associative table held in one synchronous memory. One result beat
// comes back per sighting with the slot used, whether it was a hit, a fill of the lowest free
// slot or a replacement of the entry with the smallest last-seen time, and the saturating fill
// count. The result beat is presented after the whole table has been scanned: the single memory
// read port scans one entry per cycle, the read data of each entry is registered in the memory
// before it is compared, then the chosen entry is written back in the write state. The next
// sighting is accepted in the cycle after the write, so a new sighting is not taken until the
// last one is written, while the previous result may still wait on out_ready; a result
// that is not taken holds the write of the following sighting. Per-entry written flags make
// unwritten entries read as zero, so there is no clearing pass after reset.
`default_nettype none

module mac_table_lru_allocate_top #(
    parameter int TABLE_DEPTH = mactbl_pkg::TABLE_DEPTH_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire mactbl_pkg::item_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output mactbl_pkg::result_t    out_data
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    mactbl_pkg::entry_t  rd_data;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    mactbl_pkg::entry_t  wr_data;

    mactbl_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    mactbl_mem #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

endmodule

`default_nettype wire

>>> bench/tb_mac_table_lru_allocate_top.sv
`timescale 1ns / 1ps

module tb_mac_table_lru_allocate_top;

    localparam int DEPTH        = mactbl_pkg::TABLE_DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS = 1700;
    localparam int POOL_SIZE    = 40;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 45;

    typedef struct {
        mactbl_pkg::item_t   sighting;
        bit                  typed;
        mactbl_pkg::result_t want;
    } directed_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    mactbl_pkg::item_t   in_data = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    mactbl_pkg::result_t out_data;

    // shadow copy of the sighting table
    logic [mactbl_pkg::ADDR_W-1:0]     tbl_addr [DEPTH];
    logic [mactbl_pkg::TIME_W-1:0]     tbl_seen [DEPTH];
    logic [mactbl_pkg::STRENGTH_W-1:0] tbl_strength [DEPTH];
    logic [mactbl_pkg::COUNT_W-1:0]    fill_total;

    mactbl_pkg::result_t           pending_results[$];
    directed_row_t                 directed_rows[$];
    logic [mactbl_pkg::ADDR_W-1:0] addr_pool [POOL_SIZE];
    logic [mactbl_pkg::TIME_W-1:0] clock_ms;

    int  mismatches = 0;
    int  cycle_count = 0;
    int  sent_count = 0;
    int  tally_hit = 0;
    int  tally_fill = 0;
    int  tally_replace = 0;
    int  peak_count = 0;
    bit  calm_stretch = 1'b0;

    mac_table_lru_allocate_top #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("[%0t] %s: got %0d want %0d", $time, what, got, want);
    endtask

    function automatic mactbl_pkg::result_t track_sighting(input mactbl_pkg::item_t s);
        int                   i;
        int                   chosen;
        int                   oldest;
        bit                   found;
        mactbl_pkg::outcome_t oc;
        mactbl_pkg::result_t  r;
        found  = 1'b0;
        chosen = 0;
        oldest = 0;
        oc     = mactbl_pkg::OUTCOME_REPLACE;
        for (i = 0; i < DEPTH; i++)
        begin
            if (!found && tbl_addr[i] == s.device_address)
            begin
                chosen = i;
                oc     = mactbl_pkg::OUTCOME_HIT;
                found  = 1'b1;
            end
        end
        if (!found)
        begin
            for (i = 0; i < DEPTH; i++)
            begin
                if (!found)
                begin
                    // vacant when bytes 0, 1 and 5 are zero
                    if ((tbl_addr[i][7:0] | tbl_addr[i][15:8] | tbl_addr[i][47:40]) == 8'd0)
                    begin
                        chosen = i;
                        oc     = mactbl_pkg::OUTCOME_FILL;
                        found  = 1'b1;
                        if (fill_total < mactbl_pkg::COUNT_MAX)
                            fill_total = fill_total + 1'b1;
                    end
                    else if (tbl_seen[i] < tbl_seen[oldest])
                    begin
                        oldest = i;
                    end
                end
            end
            if (!found)
                chosen = oldest;
        end
        tbl_addr[chosen]     = s.device_address;
        tbl_seen[chosen]     = s.time_ms;
        tbl_strength[chosen] = s.signal_strength;
        r.slot         = chosen[mactbl_pkg::SLOT_W-1:0];
        r.outcome      = oc;
        r.device_count = fill_total;
        return r;
    endfunction

    function automatic void add_row(input logic [mactbl_pkg::ADDR_W-1:0] a,
                                    input logic [7:0] str,
                                    input logic [mactbl_pkg::TIME_W-1:0] t, input bit typed,
                                    input int slot, input mactbl_pkg::outcome_t oc,
                                    input int cnt);
        directed_row_t row;
        row.sighting.device_address  = a;
        row.sighting.signal_strength = str;
        row.sighting.time_ms         = t;
        row.typed             = typed;
        row.want.slot         = slot[mactbl_pkg::SLOT_W-1:0];
        row.want.outcome      = oc;
        row.want.device_count = cnt[mactbl_pkg::COUNT_W-1:0];
        directed_rows.push_back(row);
    endfunction

    function automatic void refresh_pool();
        int          i;
        logic [63:0] r;
        for (i = 0; i < POOL_SIZE; i++)
        begin
            r = {$urandom, $urandom};
            addr_pool[i] = r[mactbl_pkg::ADDR_W-1:0];
        end
    endfunction

    function automatic mactbl_pkg::item_t next_random_sighting();
        mactbl_pkg::item_t s;
        logic [63:0]       r;
        int                pick;
        r    = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 72)
            s.device_address = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (pick < 84)
            s.device_address = r[mactbl_pkg::ADDR_W-1:0];
        else if (pick < 96)
            s.device_address = r[mactbl_pkg::ADDR_W-1:0] & 48'h00FF_FFFF_0000;
        else if (pick < 98)
            s.device_address = '0;
        else
            s.device_address = '1;
        r = {$urandom, $urandom};
        s.signal_strength = r[7:0];
        pick = $urandom_range(0, 99);
        // mostly creeping forward so ties and ordering matter, sometimes a jump
        if (pick < 90)
            clock_ms = clock_ms + $urandom_range(0, 3);
        else if (pick < 97)
            clock_ms = r[63:32];
        else if (pick < 99)
            clock_ms = '1;
        else
            clock_ms = '0;
        s.time_ms = clock_ms;
        return s;
    endfunction

    task automatic send_sighting(input mactbl_pkg::item_t s, input bit typed,
                                 input mactbl_pkg::result_t want);
        mactbl_pkg::result_t predicted;
        while (!calm_stretch && $urandom_range(0, 99) < 29)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = track_sighting(s);
        pending_results.push_back(typed ? want : predicted);
        case (predicted.outcome)
            mactbl_pkg::OUTCOME_HIT:  tally_hit++;
            mactbl_pkg::OUTCOME_FILL: tally_fill++;
            default:                  tally_replace++;
        endcase
        if (predicted.device_count > peak_count)
            peak_count = predicted.device_count;
        sent_count++;
        calm_stretch = (sent_count >= 700 && sent_count < 1000);
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        out_ready <= calm_stretch || ($urandom_range(0, 99) >= 29);
    end

    always @(posedge clk)
    begin : check_results
        mactbl_pkg::result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                flag_mismatch("result beat with nothing expected, slot", out_data.slot, -1);
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.slot !== want.slot)
                    flag_mismatch("slot", out_data.slot, want.slot);
                if (out_data.outcome !== want.outcome)
                    flag_mismatch("outcome", out_data.outcome, want.outcome);
                if (out_data.device_count !== want.device_count)
                    flag_mismatch("device_count", out_data.device_count, want.device_count);
            end
        end
    end

    initial
    begin : stimulus
        int                  i;
        int                  n;
        mactbl_pkg::result_t none;
        none = '0;
        for (i = 0; i < DEPTH; i++)
        begin
            tbl_addr[i]     = '0;
            tbl_seen[i]     = '0;
            tbl_strength[i] = '0;
        end
        fill_total = '0;
        clock_ms   = '0;
        refresh_pool();

        // all-zero address hits the reset contents of slot 0
        add_row(48'h0000_0000_0000, 8'h00, 32'h0000_0000, 1, 0, mactbl_pkg::OUTCOME_HIT, 0);
        // middle bytes only: misses, fills slot 0, which still looks vacant
        add_row(48'h0012_3456_0000, 8'h80, 32'hFFFF_FFFF, 1, 0, mactbl_pkg::OUTCOME_FILL, 1);
        add_row(48'h0012_3456_0000, 8'h7F, 32'h0000_0001, 1, 0, mactbl_pkg::OUTCOME_HIT, 1);
        add_row(48'h0000_0000_0000, 8'hFF, 32'h0000_0002, 1, 1, mactbl_pkg::OUTCOME_HIT, 1);
        add_row(48'hFFFF_FFFF_FFFF, 8'h7F, 32'hFFFF_FFFF, 1, 0, mactbl_pkg::OUTCOME_FILL, 2);
        add_row(48'h0000_0000_0001, 8'h80, 32'h0000_0000, 1, 1, mactbl_pkg::OUTCOME_FILL, 3);
        add_row(48'h0000_0000_0100, 8'h01, 32'h0000_0010, 1, 2, mactbl_pkg::OUTCOME_FILL, 4);
        add_row(48'h0100_0000_0000, 8'hC4, 32'h0000_0020, 1, 3, mactbl_pkg::OUTCOME_FILL, 5);
        add_row(48'h00FF_FFFF_0000, 8'hA0, 32'h0000_0030, 1, 4, mactbl_pkg::OUTCOME_FILL, 6);
        add_row(48'h8000_0000_0000, 8'hB0, 32'h0000_0040, 1, 4, mactbl_pkg::OUTCOME_FILL, 7);
        add_row(48'hFFFF_FFFF_FFFF, 8'h80, 32'h0000_0000, 1, 0, mactbl_pkg::OUTCOME_HIT, 7);
        add_row(48'h0000_0000_0001, 8'h7F, 32'hFFFF_FFFF, 1, 1, mactbl_pkg::OUTCOME_HIT, 7);
        add_row(48'hA5A5_A5A5_A5A5, 8'hFF, 32'h0000_0100, 0, 0, mactbl_pkg::OUTCOME_HIT, 0);
        add_row(48'h5A5A_5A5A_5A5A, 8'h01, 32'h0000_0100, 0, 0, mactbl_pkg::OUTCOME_HIT, 0);
        add_row(48'h1234_5678_9ABC, 8'h55, 32'h0000_0050, 0, 0, mactbl_pkg::OUTCOME_HIT, 0);
        add_row(48'h00AA_BBCC_0000, 8'hAA, 32'h8000_0000, 0, 0, mactbl_pkg::OUTCOME_HIT, 0);
        add_row(48'hA5A5_A5A5_A5A5, 8'h00, 32'h0000_0200, 0, 0, mactbl_pkg::OUTCOME_HIT, 0);
        add_row(48'hFFFF_FFFF_FFFE, 8'h80, 32'h7FFF_FFFF, 0, 0, mactbl_pkg::OUTCOME_HIT, 0);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (i = 0; i < directed_rows.size(); i++)
            send_sighting(directed_rows[i].sighting, directed_rows[i].typed,
                          directed_rows[i].want);

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            // swap in fresh addresses now and then so the table keeps churning
            if (n % 200 == 199)
                refresh_pool();
            send_sighting(next_random_sighting(), 1'b0, none);
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d sightings: %0d hits, %0d fills, %0d replacements of the oldest entry",
                 sent_count, tally_hit, tally_fill, tally_replace);
        $display("fill counter peaked at %0d, %0d mismatches", peak_count, mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> filelist.f
hdl/mactbl_pkg.sv
hdl/mactbl_mem.sv
hdl/mactbl_ctrl.sv
hdl/mac_table_lru_allocate_top.sv
bench/tb_mac_table_lru_allocate_top.sv
